### sv/cbq_pkg.sv
// Package for the circular byte queue.
// Holds field widths, operation and outcome codes and the command type.
// No dependencies.
package cbq_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 8;
  localparam int OUTC_W  = 3;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;

  localparam logic [OUTC_W-1:0] OUTC_PUSHED     = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_OVERFLOW   = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_POPPED     = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_UNDERFLOW  = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_LISTED     = 3'd4;
  localparam logic [OUTC_W-1:0] OUTC_LIST_EMPTY = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]  op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

### sv/circular_byte_queue.sv
// Circular byte queue: a ring-buffer FIFO of DEPTH bytes driven by push, pop
// and list commands. A push writes the storage directly; a pop and a list
// read it through the registered read of the storage memory, and a list of N
// stored bytes streams one byte per cycle while the result is not stalled. A
// two-entry command queue sits between the decoding front end and the engine,
// so up to two further commands are taken while a list streams or a result
// waits. Storage is not cleared at reset; only entries written by a push are
// ever read. Items with an unused kind are taken and produce no result.
module circular_byte_queue #(
  parameter int DEPTH = cbq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [cbq_pkg::KIND_W-1:0]   kind,
  input  logic [cbq_pkg::VALUE_W-1:0]  push_value,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [cbq_pkg::OUTC_W-1:0]   outcome,
  output logic [cbq_pkg::VALUE_W-1:0]  out_value,
  output logic                         last,
  output logic                         now_empty,
  output logic                         now_full
);
  import cbq_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_in_cmd;
  logic q_not_empty;
  cmd_t q_head_cmd;
  logic q_pop;

  cbq_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .kind       (kind),
    .push_value (push_value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in_cmd)
  );

  cbq_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (q_head_cmd),
    .pop       (q_pop)
  );

  cbq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .outcome   (outcome),
    .out_value (out_value),
    .last      (last),
    .now_empty (now_empty),
    .now_full  (now_full),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

### sv/cbq_front.sv
// Front end of the circular byte queue: accepts input items and decodes them.
// Items with an unused kind are dropped here. Depends on cbq_pkg.
module cbq_front (
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [cbq_pkg::KIND_W-1:0]   kind,
  input  logic [cbq_pkg::VALUE_W-1:0]  push_value,
  input  logic                         q_full,
  output logic                         q_push,
  output cbq_pkg::cmd_t                q_cmd
);
  import cbq_pkg::*;

  logic known;

  always_comb begin
    case (kind)
      KIND_PUSH, KIND_POP, KIND_LIST: known = 1'b1;
      default:                        known = 1'b0;
    endcase
  end

  // An unknown item is still a transfer on the input side; it just never
  // reaches the command queue.
  assign cmd_stall    = q_full;
  assign q_push       = cmd_valid && !q_full && known;
  assign q_cmd.op     = kind;
  assign q_cmd.value  = (kind == KIND_PUSH) ? push_value : '0;

endmodule

### sv/cbq_cmd_fifo.sv
// Two-entry command queue between the front end and the execution engine.
// Depends on cbq_pkg for the command type.
module cbq_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbq_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          not_empty,
  output cbq_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import cbq_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/cbq_back.sv
// Execution engine of the circular byte queue: ring storage, head and
// occupancy, list sequencing and the result register. Depends on cbq_pkg.
module cbq_back #(
  parameter int DEPTH = cbq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  cbq_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  output logic [cbq_pkg::OUTC_W-1:0]   outcome,
  output logic [cbq_pkg::VALUE_W-1:0]  out_value,
  output logic                         last,
  output logic                         now_empty,
  output logic                         now_full,
  output logic                         res_valid,
  input  logic                         res_stall
);
  import cbq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;

  logic          state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] occ, occ_next;
  logic [AW-1:0] idx, idx_next;
  logic          cur_list, cur_list_next;

  logic               out_free;
  logic               out_load;
  logic [OUTC_W-1:0]  res_outcome;
  logic [VALUE_W-1:0] res_value;
  logic               res_last;
  logic [CW-1:0]      res_occ;

  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               occ_full;
  logic               occ_zero;
  logic               list_end;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free = !res_valid || !res_stall;
  assign occ_full = (occ == CW'(DEPTH));
  assign occ_zero = (occ == '0);
  assign list_end = ((CW'(idx) + CW'(1)) == occ);

  always_comb begin
    state_next    = state;
    head_next     = head;
    occ_next      = occ;
    idx_next      = idx;
    cur_list_next = cur_list;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    res_outcome   = OUTC_PUSHED;
    res_value     = '0;
    res_last      = 1'b1;
    res_occ       = occ;
    mem_we        = 1'b0;
    wr_addr       = ring(head, occ[AW-1:0]);
    rd_en         = 1'b0;
    rd_addr       = head;

    case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            KIND_PUSH: begin
              out_load = 1'b1;
              if (occ_full) begin
                res_outcome = OUTC_OVERFLOW;
              end else begin
                mem_we      = 1'b1;
                occ_next    = occ + CW'(1);
                res_occ     = occ + CW'(1);
                res_outcome = OUTC_PUSHED;
                res_value   = q_cmd.value;
              end
            end
            KIND_POP: begin
              if (occ_zero) begin
                out_load    = 1'b1;
                res_outcome = OUTC_UNDERFLOW;
              end else begin
                rd_en         = 1'b1;
                cur_list_next = 1'b0;
                state_next    = ST_READ;
              end
            end
            KIND_LIST: begin
              if (occ_zero) begin
                out_load    = 1'b1;
                res_outcome = OUTC_LIST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                idx_next      = '0;
                cur_list_next = 1'b1;
                state_next    = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // The registered read data is held until the result slot frees up.
        if (out_free) begin
          out_load  = 1'b1;
          res_value = rdata;
          if (!cur_list) begin
            res_outcome = OUTC_POPPED;
            occ_next    = occ - CW'(1);
            res_occ     = occ - CW'(1);
            head_next   = (occ == CW'(1)) ? '0 : ring(head, AW'(1));
            state_next  = ST_IDLE;
          end else begin
            res_outcome = OUTC_LISTED;
            res_last    = list_end;
            if (list_end) begin
              state_next = ST_IDLE;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = ring(head, idx + AW'(1));
              idx_next = idx + AW'(1);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_cmd.value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      outcome   <= res_outcome;
      out_value <= res_value;
      last      <= res_last;
      now_empty <= (res_occ == '0);
      now_full  <= (res_occ == CW'(DEPTH));
    end
    idx      <= idx_next;
    cur_list <= cur_list_next;
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### dv/tb.sv
// Testbench for circular_byte_queue: directed and random push, pop and list
// commands, with every result checked against an in-bench queue predictor.
// Depends on cbq_pkg (sv/cbq_pkg.sv) and the circular_byte_queue RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbq_pkg::*;

  localparam int CAPACITY = DEPTH_DEFAULT;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_CMDS = 75;
  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    logic [OUTC_W-1:0]  outcome;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               empty;
    logic               full;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [VALUE_W-1:0] push_value = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [OUTC_W-1:0] outcome;
  logic [VALUE_W-1:0] out_value;
  logic last;
  logic now_empty;
  logic now_full;

  circular_byte_queue #(.DEPTH(CAPACITY)) uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .kind(kind), .push_value(push_value),
    .res_valid(res_valid), .res_stall(res_stall),
    .outcome(outcome), .out_value(out_value), .last(last),
    .now_empty(now_empty), .now_full(now_full)
  );

  always #4 clk = ~clk;

  // Predicted queue contents.
  logic [VALUE_W-1:0] ring [CAPACITY];
  int unsigned ring_head = 0;
  int unsigned ring_count = 0;

  queue_reply_t due_results [$];
  cmd_t cmd_backlog [$];
  cmd_t next_cmd;
  int unsigned gen_count = 0;

  int errors = 0;
  int cmds_taken = 0;
  int results_checked = 0;
  int lists_seen = 0;
  int overflows_seen = 0;
  int underflows_seen = 0;
  int full_seen = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic post_reply(input logic [OUTC_W-1:0] oc, input logic [VALUE_W-1:0] v,
                            input logic is_last);
    queue_reply_t r;
    r.outcome = oc;
    r.value = v;
    r.last = is_last;
    r.empty = (ring_count == 0);
    r.full = (ring_count == CAPACITY);
    if (r.full) full_seen++;
    due_results.push_back(r);
  endtask

  task automatic apply_queue_op(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
    case (k)
      KIND_PUSH: begin
        if (ring_count == CAPACITY) begin
          overflows_seen++;
          post_reply(OUTC_OVERFLOW, '0, 1'b1);
        end else begin
          ring[(ring_head + ring_count) % CAPACITY] = v;
          ring_count++;
          post_reply(OUTC_PUSHED, v, 1'b1);
        end
      end
      KIND_POP: begin
        if (ring_count == 0) begin
          underflows_seen++;
          post_reply(OUTC_UNDERFLOW, '0, 1'b1);
        end else begin
          logic [VALUE_W-1:0] oldest;
          oldest = ring[ring_head];
          ring_count--;
          ring_head = (ring_count == 0) ? 0 : (ring_head + 1) % CAPACITY;
          post_reply(OUTC_POPPED, oldest, 1'b1);
        end
      end
      KIND_LIST: begin
        lists_seen++;
        if (ring_count == 0) begin
          post_reply(OUTC_LIST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++)
            post_reply(OUTC_LISTED, ring[(ring_head + i) % CAPACITY],
                       i == ring_count - 1);
        end
      end
      default: ;  // unused kind: taken, no result, queue unchanged
    endcase
  endtask

  // Stimulus builder; tracks its own fill level to shape sequences.
  task automatic queue_cmd(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
    cmd_t c;
    c.op = k;
    c.value = v;
    cmd_backlog.push_back(c);
    if (k == KIND_PUSH && gen_count < CAPACITY) gen_count++;
    if (k == KIND_POP && gen_count > 0) gen_count--;
  endtask

  task automatic fill_to_full();
    while (gen_count < CAPACITY) queue_cmd(KIND_PUSH, VALUE_W'($urandom));
    repeat ($urandom_range(1, 2)) queue_cmd(KIND_PUSH, VALUE_W'($urandom));
    queue_cmd(KIND_LIST, VALUE_W'($urandom));
  endtask

  task automatic drain_to_empty();
    while (gen_count > 0) queue_cmd(KIND_POP, VALUE_W'($urandom));
    queue_cmd(KIND_POP, VALUE_W'($urandom));
    queue_cmd(KIND_LIST, VALUE_W'($urandom));
  endtask

  task automatic mixed_ops(input int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_cmd(KIND_PUSH, VALUE_W'($urandom));
      else if (r < 80) queue_cmd(KIND_POP, VALUE_W'($urandom));
      else if (r < 92) queue_cmd(KIND_LIST, VALUE_W'($urandom));
      else queue_cmd(KIND_UNUSED, VALUE_W'($urandom));
    end
  endtask

  // Command driver.
  int unsigned cmd_gap_left = 0;
  int unsigned cmd_phase_left = 0;
  bit cmd_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        apply_queue_op(kind, push_value);
        cmds_taken++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_phase_left == 0) begin
          cmd_calm = ($urandom_range(0, 2) == 0);
          cmd_phase_left = $urandom_range(8, 40);
        end
        cmd_phase_left--;
        if (cmd_gap_left > 0) begin
          cmd_gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          next_cmd = cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
          kind <= next_cmd.op;
          push_value <= next_cmd.value;
          cmd_gap_left = cmd_calm ? 0 : pick_gap();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall generator.
  int unsigned stall_left = 0;
  int unsigned stall_phase_left = 0;
  bit stall_calm = 1'b0;

  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_calm = ($urandom_range(0, 2) == 0);
      stall_phase_left = $urandom_range(10, 60);
    end
    stall_phase_left--;
    if (stall_left == 0 && !stall_calm) stall_left = pick_gap();
    if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Result monitor.
  queue_reply_t want;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, outcome %0d value %0d",
                 $time, outcome, out_value);
      end else begin
        want = due_results.pop_front();
        check_field("outcome", want.outcome, outcome);
        check_field("out_value", want.value, out_value);
        check_field("last", want.last, last);
        check_field("now_empty", want.empty, now_empty);
        check_field("now_full", want.full, now_full);
        results_checked++;
      end
    end
  end

  // A transfer on either side resets the stuck counter.
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int directed_len;

    // Directed: empty corner cases, value extremes, ignored kind, head reset.
    queue_cmd(KIND_LIST, 8'h00);
    queue_cmd(KIND_POP, 8'hFF);
    queue_cmd(KIND_PUSH, 8'h00);
    queue_cmd(KIND_PUSH, 8'hFF);
    queue_cmd(KIND_PUSH, 8'hA5);
    queue_cmd(KIND_LIST, 8'h00);
    queue_cmd(KIND_UNUSED, 8'hFF);
    queue_cmd(KIND_POP, 8'h00);
    queue_cmd(KIND_PUSH, 8'h5A);
    queue_cmd(KIND_LIST, 8'hFF);
    queue_cmd(KIND_POP, 8'h00);
    queue_cmd(KIND_POP, 8'h00);
    queue_cmd(KIND_POP, 8'h00);
    queue_cmd(KIND_POP, 8'h00);
    queue_cmd(KIND_LIST, 8'h00);
    queue_cmd(KIND_PUSH, 8'h01);
    queue_cmd(KIND_PUSH, 8'h80);
    queue_cmd(KIND_POP, 8'h00);
    queue_cmd(KIND_LIST, 8'h00);
    queue_cmd(KIND_UNUSED, 8'h00);
    queue_cmd(KIND_POP, 8'h00);
    directed_len = cmd_backlog.size();

    // Random: reach full and overflow first, then a mix that wraps the ring.
    fill_to_full();
    mixed_ops($urandom_range(6, 16));
    while (cmd_backlog.size() - directed_len < RANDOM_CMDS) begin
      case ($urandom_range(0, 9))
        0: fill_to_full();
        1, 2: drain_to_empty();
        default: mixed_ops($urandom_range(6, 16));
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || cmd_valid || due_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Took %0d commands (%0d lists) and checked %0d results.",
             cmds_taken, lists_seen, results_checked);
    $display("Saw %0d overflows, %0d underflows and %0d results with the queue full.",
             overflows_seen, underflows_seen, full_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
